// ----- src/fmacl_pkg.sv -----
package fmacl_pkg;

  localparam int RULE_COUNT_DEF = 128;
  localparam int SLOT_W         = 7;
  localparam logic [31:0] ACTION_END = 32'd0;
  localparam logic [31:0] ACT_DROP   = 32'd1;
  localparam logic [31:0] ACT_PASS   = 32'd2;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_WRITE  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [31:0] action;
    logic [31:0] v4_net;
    logic [31:0] v4_mask;
    logic [63:0] v6_net_hi;
    logic [63:0] v6_net_lo;
    logic [63:0] v6_mask_hi;
    logic [63:0] v6_mask_lo;
  } rule_t;

  typedef struct packed {
    logic        is_ipv6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } key_t;

  // status a cell reports while it holds the scan token
  typedef struct packed {
    logic live;
    logic done;
    logic matched;
    logic drop;
  } cell_res_t;

endpackage

// ----- src/first_match_subnet_acl.sv -----
// First-match access list over RULE_COUNT subnet rules, one rule per cell in a
// chain. A write's result strobes on out_valid the next cycle. A lookup passes
// a token down the chain, one rule per cycle, and ends at the first matching
// rule or the first rule with action zero; busy stays high until the result
// is reported. The result is on the out_ ports for exactly one cycle with
// out_valid; there is no backpressure, so the receiver must take it.
// After reset every rule acts as an end rule (action zero); the other rule fields are not reset.
module first_match_subnet_acl #(
  parameter int RULE_COUNT = fmacl_pkg::RULE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [6:0]  in_entry_index,
  input  logic        in_is_ipv6,
  input  logic [63:0] in_addr_hi,
  input  logic [63:0] in_addr_lo,
  input  logic [31:0] in_entry_action,
  input  logic [31:0] in_entry_v4_net,
  input  logic [31:0] in_entry_v4_mask,
  input  logic [63:0] in_entry_v6_net_hi,
  input  logic [63:0] in_entry_v6_net_lo,
  input  logic [63:0] in_entry_v6_mask_hi,
  input  logic [63:0] in_entry_v6_mask_lo,
  output logic        out_valid,
  output logic        out_drop,
  output logic        out_matched,
  output logic [6:0]  out_match_slot
);
  import fmacl_pkg::*;

  logic        accept;
  logic        acc_lookup;
  logic        acc_write;
  rule_t       wr_rule;
  key_t        key_r;
  logic        busy_r;
  logic        out_valid_r;
  logic        out_drop_r;
  logic        out_matched_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic [RULE_COUNT:0]   tok;
  cell_res_t             res [RULE_COUNT];
  logic [RULE_COUNT-1:0] live_vec;
  logic                  done_any;
  logic                  match_any;
  logic                  drop_any;
  logic [SLOT_W-1:0]     slot_any;

  assign accept     = start && !busy_r;
  assign acc_lookup = accept && (cmd_t'(in_command) == CMD_LOOKUP);
  assign acc_write  = accept && (cmd_t'(in_command) == CMD_WRITE);

  assign wr_rule = '{action:     in_entry_action,
                     v4_net:     in_entry_v4_net,
                     v4_mask:    in_entry_v4_mask,
                     v6_net_hi:  in_entry_v6_net_hi,
                     v6_net_lo:  in_entry_v6_net_lo,
                     v6_mask_hi: in_entry_v6_mask_hi,
                     v6_mask_lo: in_entry_v6_mask_lo};

  assign tok[0] = acc_lookup;

  for (genvar i = 0; i < RULE_COUNT; i++) begin : g_cell
    logic wr_sel;
    assign wr_sel = acc_write && ({25'd0, in_entry_index} == i);
    fmacl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_sel),
      .wr_rule (wr_rule),
      .key     (key_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .res     (res[i])
    );
    assign live_vec[i] = res[i].live;
  end

  // only one cell holds the token, so the reports just OR together
  always_comb begin
    done_any  = tok[RULE_COUNT];
    match_any = 1'b0;
    drop_any  = 1'b0;
    slot_any  = '0;
    for (int i = 0; i < RULE_COUNT; i++) begin
      done_any  = done_any  | res[i].done;
      match_any = match_any | res[i].matched;
      drop_any  = drop_any  | res[i].drop;
      if (res[i].matched) begin
        slot_any = slot_any | SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_lookup) begin
      key_r <= '{is_ipv6: in_is_ipv6, addr_hi: in_addr_hi, addr_lo: in_addr_lo};
    end
    if (acc_write) begin
      out_drop_r    <= 1'b0;
      out_matched_r <= 1'b0;
      out_slot_r    <= '0;
    end else if (busy_r && done_any) begin
      out_drop_r    <= drop_any;
      out_matched_r <= match_any;
      out_slot_r    <= slot_any;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= acc_write || (busy_r && done_any);
      if (acc_lookup) begin
        busy_r <= 1'b1;
      end else if (done_any) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_drop       = out_drop_r;
  assign out_matched    = out_matched_r;
  assign out_match_slot = out_slot_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(live_vec))
    else $error("more than one cell holds the scan token");

  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (live_vec == '0))
    else $error("token in chain while idle");

  a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r)
    else $error("lookup ended without a result");

  a_drop_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_drop_r |-> out_matched_r)
    else $error("drop without a matching rule");

endmodule

// ----- src/fmacl_cell.sv -----
module fmacl_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  fmacl_pkg::rule_t  wr_rule,
  input  fmacl_pkg::key_t   key,
  input  logic              tok_in,
  output logic              tok_out,
  output fmacl_pkg::cell_res_t res
);
  import fmacl_pkg::*;

  rule_t rule_r;
  logic  action_zero_r;
  logic  tok_r;
  logic  mask_valid;
  logic  hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      action_zero_r <= 1'b1;
      tok_r         <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (wr_en) begin
        action_zero_r <= (wr_rule.action == ACTION_END);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_r <= wr_rule;
    end
  end

  always_comb begin
    mask_valid = rule_r.v6_mask_hi[63];
    if (!key.is_ipv6) begin
      if (rule_r.v4_net == 32'd0) begin
        hit = !mask_valid;
      end else begin
        hit = ((key.addr_lo[31:0] & rule_r.v4_mask) == rule_r.v4_net);
      end
    end else if (!mask_valid) begin
      hit = (rule_r.v4_mask == 32'd0);
    end else begin
      hit = ((key.addr_hi & rule_r.v6_mask_hi) == rule_r.v6_net_hi) &&
            ((key.addr_lo & rule_r.v6_mask_lo) == rule_r.v6_net_lo);
    end
  end

  assign tok_out     = tok_r && !action_zero_r && !hit;
  assign res.live    = tok_r;
  assign res.done    = tok_r && (action_zero_r || hit);
  assign res.matched = tok_r && !action_zero_r && hit;
  assign res.drop    = tok_r && !action_zero_r && hit && (rule_r.action == ACT_DROP);

endmodule

// ----- sim/first_match_subnet_acl_chk.sv -----
`timescale 1ns / 1ps

module first_match_subnet_acl_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_command,
  input  logic [6:0]  in_entry_index,
  input  logic        in_is_ipv6,
  input  logic [63:0] in_addr_hi,
  input  logic [63:0] in_addr_lo,
  input  logic [31:0] in_entry_action,
  input  logic [31:0] in_entry_v4_net,
  input  logic [31:0] in_entry_v4_mask,
  input  logic [63:0] in_entry_v6_net_hi,
  input  logic [63:0] in_entry_v6_net_lo,
  input  logic [63:0] in_entry_v6_mask_hi,
  input  logic [63:0] in_entry_v6_mask_lo,
  input  logic        out_valid,
  input  logic        out_drop,
  input  logic        out_matched,
  input  logic [6:0]  out_match_slot,
  output int          fail_count,
  output int          pending
);
  import fmacl_pkg::*;

  typedef struct packed {
    logic       drop;
    logic       matched;
    logic [6:0] slot;
  } verdict_t;

  rule_t    acl [RULE_COUNT_DEF];
  verdict_t verdict_q [$];

  assign pending = verdict_q.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic rule_hit(rule_t r, logic v6, logic [63:0] hi, logic [63:0] lo);
    logic valid6;
    valid6 = r.v6_mask_hi[63];
    if (!v6) begin
      if (r.v4_net == '0) return !valid6;
      return (lo[31:0] & r.v4_mask) == r.v4_net;
    end
    if (!valid6) return r.v4_mask == '0;
    return ((hi & r.v6_mask_hi) == r.v6_net_hi) && ((lo & r.v6_mask_lo) == r.v6_net_lo);
  endfunction

  function automatic verdict_t acl_lookup(logic v6, logic [63:0] hi, logic [63:0] lo);
    verdict_t v;
    v = '0;
    for (int i = 0; i < RULE_COUNT_DEF; i++) begin
      if (acl[i].action == ACTION_END) break;
      if (rule_hit(acl[i], v6, hi, lo)) begin
        v.drop = (acl[i].action == ACT_DROP);
        v.matched = 1'b1;
        v.slot = i[6:0];
        break;
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t got, exp_v;
    if (!rst_n) begin
      for (int i = 0; i < RULE_COUNT_DEF; i++) acl[i] = '0;
      verdict_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        got = '{out_drop, out_matched, out_match_slot};
        if (verdict_q.size() == 0) report("result with no item outstanding");
        else begin
          exp_v = verdict_q.pop_front();
          if (got.drop !== exp_v.drop)
            report($sformatf("drop %b exp %b", got.drop, exp_v.drop));
          if (got.matched !== exp_v.matched)
            report($sformatf("matched %b exp %b", got.matched, exp_v.matched));
          if (got.slot !== exp_v.slot)
            report($sformatf("slot %0d exp %0d", got.slot, exp_v.slot));
        end
      end
      if (start && !busy) begin
        if (cmd_t'(in_command) == CMD_WRITE) begin
          acl[in_entry_index] = '{in_entry_action, in_entry_v4_net, in_entry_v4_mask,
                                  in_entry_v6_net_hi, in_entry_v6_net_lo,
                                  in_entry_v6_mask_hi, in_entry_v6_mask_lo};
          verdict_q.push_back('0);
        end else
          verdict_q.push_back(acl_lookup(in_is_ipv6, in_addr_hi, in_addr_lo));
      end
    end
  end

endmodule

// ----- sim/first_match_subnet_acl_tb.sv -----
`timescale 1ns / 1ps

module first_match_subnet_acl_tb;
  import fmacl_pkg::*;

  logic        clk, rst_n, start, busy;
  logic        in_command, in_is_ipv6;
  logic [6:0]  in_entry_index;
  logic [63:0] in_addr_hi, in_addr_lo;
  logic [31:0] in_entry_action, in_entry_v4_net, in_entry_v4_mask;
  logic [63:0] in_entry_v6_net_hi, in_entry_v6_net_lo;
  logic [63:0] in_entry_v6_mask_hi, in_entry_v6_mask_lo;
  logic        out_valid, out_drop, out_matched;
  logic [6:0]  out_match_slot;
  int          fail_count, pending;
  int          idle_pct;
  logic [6:0]  list_len;

  first_match_subnet_acl DUT (.*);
  first_match_subnet_acl_chk u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("first_match_subnet_acl_tb failed");
    $finish;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] prefix32(int n);
    return (n == 0) ? 32'h0 : ~32'h0 << (32 - n);
  endfunction

  // one item: waits for acceptance, random sender gaps before it
  task automatic send_item(input logic cmd, input logic [6:0] idx, input logic v6,
                           input logic [63:0] ahi, input logic [63:0] alo,
                           input logic [31:0] act, input logic [31:0] n4,
                           input logic [31:0] m4, input logic [63:0] n6h,
                           input logic [63:0] n6l, input logic [63:0] m6h,
                           input logic [63:0] m6l);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_entry_v6_mask_hi <= rnd64(); // junk on ignored fields while idle
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;         in_entry_index <= idx;
    in_is_ipv6 <= v6;          in_addr_hi <= ahi;            in_addr_lo <= alo;
    in_entry_action <= act;    in_entry_v4_net <= n4;        in_entry_v4_mask <= m4;
    in_entry_v6_net_hi <= n6h; in_entry_v6_net_lo <= n6l;
    in_entry_v6_mask_hi <= m6h; in_entry_v6_mask_lo <= m6l;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic lookup(input logic v6, input logic [63:0] ahi, input logic [63:0] alo);
    send_item(CMD_LOOKUP, 7'($urandom), v6, ahi, alo, $urandom, $urandom, $urandom,
              rnd64(), rnd64(), rnd64(), rnd64());
  endtask

  task automatic write_rule(input logic [6:0] idx, input logic [31:0] act,
                            input logic [31:0] n4, input logic [31:0] m4,
                            input logic [63:0] n6h, input logic [63:0] n6l,
                            input logic [63:0] m6h, input logic [63:0] m6l);
    send_item(CMD_WRITE, idx, 1'($urandom), rnd64(), rnd64(), act, n4, m4,
              n6h, n6l, m6h, m6l);
  endtask

  // random subnet rule, often matching the address family in use
  task automatic random_rule(input logic [6:0] idx, input logic [31:0] act);
    logic [31:0] m4;
    logic [63:0] m6h, m6l, a6h, a6l;
    logic [31:0] a4;
    m4 = prefix32($urandom_range(32));
    a4 = $urandom;
    m6h = (~64'h0 << $urandom_range(63));
    m6l = ($urandom_range(1)) ? ~64'h0 << $urandom_range(64) : 64'h0;
    if (m6l != 0) m6h = ~64'h0;
    if ($urandom_range(3) == 0) m6h[63] = 1'b0;
    a6h = rnd64(); a6l = rnd64();
    case ($urandom_range(5))
      0: write_rule(idx, act, 32'h0, m4, a6h & m6h, a6l & m6l, m6h, m6l);
      1: write_rule(idx, act, 32'h0, 32'h0, rnd64(), rnd64(), rnd64(), rnd64());
      default: write_rule(idx, act, $urandom_range(1) ? a4 & m4 : $urandom, m4,
                          a6h & m6h, a6l & m6l, m6h, m6l);
    endcase
  endtask

  task automatic random_lookup();
    logic [63:0] hi, lo;
    hi = rnd64(); lo = rnd64();
    // bias toward few prefixes so rules hit
    if ($urandom_range(1)) begin
      hi[63:40] = 24'h200100 | 24'($urandom_range(3));
      lo[31:24] = 8'd10 + 8'($urandom_range(1));
    end
    lookup(1'($urandom), hi, lo);
  endtask

  initial begin
    start = 0; in_command = 0; in_entry_index = 0; in_is_ipv6 = 0;
    in_addr_hi = 0; in_addr_lo = 0; in_entry_action = 0; in_entry_v4_net = 0;
    in_entry_v4_mask = 0; in_entry_v6_net_hi = 0; in_entry_v6_net_lo = 0;
    in_entry_v6_mask_hi = 0; in_entry_v6_mask_lo = 0;
    idle_pct = 0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table passes everything
    lookup(1'b0, 64'h0, 64'h0);
    lookup(1'b1, ~64'h0, ~64'h0);
    // IPv4 10.0.0.0/8 block, IPv6 2001::/16 allow, defaults
    write_rule(7'd0, ACT_DROP, 32'h0A000000, 32'hFF000000, 64'h0, 64'h0, 64'h0, 64'h0);
    write_rule(7'd1, ACT_PASS, 32'h0, 32'hFFFFFFFF, 64'h2001_0000_0000_0000, 64'h0,
               64'hFFFF_0000_0000_0000, 64'h0);
    write_rule(7'd2, 32'hFFFFFFFF, 32'hC0A80000, 32'hFFFF0000, 64'h0, 64'h0, 64'h0, 64'h0);
    write_rule(7'd3, ACT_DROP, 32'h0, 32'h0, 64'h0, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0);
    lookup(1'b0, ~64'h0, 64'hFFFF_FFFF_0A01_0203);
    lookup(1'b0, 64'h0, 64'h0);
    lookup(1'b0, 64'h0, 64'hC0A8_0101);
    lookup(1'b1, 64'h2001_0DB8_0000_0000, 64'h1);
    lookup(1'b1, 64'h3000_0000_0000_0000, 64'h0);
    // exact /128 IPv6 rule at top slot behind a non-zero chain; IPv6 keys stop at slot 3 first
    write_rule(7'd3, ACT_PASS, 32'h1, 32'h0, 64'h0, 64'h0, 64'h0, 64'h0);
    for (int i = 4; i < 127; i++)
      write_rule(i[6:0], ACT_PASS, 32'h1, 32'hFFFFFFFF, 64'h0, 64'h0, 64'h0, 64'h0);
    write_rule(7'd127, ACT_DROP, 32'hFFFFFFFF, 32'hFFFFFFFF, ~64'h0, ~64'h0, ~64'h0, ~64'h0);
    lookup(1'b1, ~64'h0, ~64'h0);
    lookup(1'b0, 64'h0, 64'hFFFFFFFF);
    lookup(1'b1, ~64'h0, 64'h0);

    // random phases: rebuild a short list, then look up against it
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 49 : (ph == 2) ? 20 : 0;
      for (int blk = 0; blk < 10; blk++) begin
        list_len = 7'($urandom_range(1, 12));
        for (int i = 0; i < list_len; i++)
          random_rule(i[6:0], $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 2));
        if ($urandom_range(3) == 0)
          write_rule(list_len, ACTION_END, $urandom, $urandom, rnd64(), rnd64(), rnd64(), rnd64());
        for (int k = 0; k < 15; k++) random_lookup();
      end
    end

    idle_pct = 0;
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("first_match_subnet_acl_tb passed");
    else
      $display("first_match_subnet_acl_tb failed");
    $finish;
  end

endmodule
